@@ rtl/core/ps2kb_pkg.sv @@
// shared types, codes and lookup tables for the set 1 keyboard decoder
package ps2kb_pkg;

    // scan code framing bytes
    localparam logic [7:0] BYTE_E0      = 8'hE0;
    localparam logic [7:0] BYTE_E1      = 8'hE1;
    localparam logic [7:0] BYTE_PS_MAKE = 8'h2A;
    localparam logic [7:0] BYTE_PS_BRK  = 8'hB7;
    localparam logic [7:0] BYTE_PS_END  = 8'h37;
    localparam logic [7:0] BYTE_PS_REL  = 8'hAA;
    localparam logic [7:0] BYTE_PA_MK1  = 8'h1D;
    localparam logic [7:0] BYTE_PA_MK2  = 8'h45;
    localparam logic [7:0] BYTE_PA_BK1  = 8'h9D;
    localparam logic [7:0] BYTE_PA_BK2  = 8'hC5;

    // special key ids
    localparam logic [7:0] KID_PRTSCR   = 8'hB7;
    localparam logic [7:0] KID_PAUSE    = 8'hC5;
    localparam logic [7:0] KID_LSHIFT   = 8'h2A;
    localparam logic [7:0] KID_RSHIFT   = 8'h36;
    localparam logic [7:0] KID_LCTRL    = 8'h1D;
    localparam logic [7:0] KID_RCTRL    = 8'h9D;
    localparam logic [7:0] KID_LALT     = 8'h38;
    localparam logic [7:0] KID_RALT     = 8'hB8;
    localparam logic [7:0] KID_CAPS     = 8'h3A;
    localparam logic [7:0] KID_NUM      = 8'h45;
    localparam logic [7:0] KID_SCROLL   = 8'h46;
    localparam logic [7:0] KID_KP_MINUS = 8'h4A;
    localparam logic [7:0] KID_KP_PLUS  = 8'h4E;
    localparam logic [7:0] KID_KP_ENTER = 8'h9C;
    localparam logic [7:0] KID_KP_DIV   = 8'hB5;
    localparam logic [7:0] KID_KP_FIVE  = 8'h4C;
    localparam logic [7:0] KID_KP_POINT = 8'h53;
    localparam logic [7:0] KID_KP_FIRST = 8'h47;
    localparam logic [7:0] KID_CHAR_END = 8'h3A;

    // ascii codes used by the keypad and for letter case
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_SLASH = 7'h2F;
    localparam logic [6:0] CH_POINT = 7'h2E;
    localparam logic [6:0] CH_LOW_A = 7'h61;
    localparam logic [6:0] CH_LOW_Z = 7'h7A;
    localparam logic [6:0] CH_CASE  = 7'h20;

    localparam int DATA_W = 8;
    localparam int RES_W  = 24;

    // sequence parser phases
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_E0      = 3'd1,
        PH_PS_HALF = 3'd2,
        PH_PS_E0   = 3'd3,
        PH_E1      = 3'd4,
        PH_E1_MID  = 3'd5
    } ps2kb_phase_t;

    // one decoded key event from parser to translator
    typedef struct packed {
        logic       valid;
        logic [7:0] id;
        logic       down;
    } ps2kb_event_t;

    // one translated result word
    typedef struct packed {
        logic [7:0] key_id;
        logic       pressed;
        logic       is_char;
        logic [6:0] char_code;
        logic       caps_lock;
        logic       num_lock;
        logic       scroll_lock;
    } ps2kb_result_t;

    // non-extended codes with a key behind them
    function automatic logic plain_known(input logic [6:0] c);
        plain_known = (c >= 7'h01 && c <= 7'h53) || c == 7'h57 || c == 7'h58;
    endfunction

    // extended codes with a key behind them
    function automatic logic ext_known(input logic [6:0] c);
        case (c)
            7'h10, 7'h19, 7'h1C, 7'h1D, 7'h20, 7'h21, 7'h22, 7'h24, 7'h2E,
            7'h30, 7'h32, 7'h35, 7'h38, 7'h47, 7'h48, 7'h49, 7'h4B, 7'h4D,
            7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h5B, 7'h5C, 7'h5D, 7'h5E,
            7'h5F, 7'h63, 7'h65, 7'h66, 7'h67, 7'h68, 7'h69, 7'h6A, 7'h6B,
            7'h6C, 7'h6D: ext_known = 1'b1;
            default:      ext_known = 1'b0;
        endcase
    endfunction

    // unshifted character for make codes below 0x3a
    function automatic logic [6:0] plain_char(input logic [5:0] c);
        case (c)
            6'h02: plain_char = 7'h31;  6'h03: plain_char = 7'h32;
            6'h04: plain_char = 7'h33;  6'h05: plain_char = 7'h34;
            6'h06: plain_char = 7'h35;  6'h07: plain_char = 7'h36;
            6'h08: plain_char = 7'h37;  6'h09: plain_char = 7'h38;
            6'h0A: plain_char = 7'h39;  6'h0B: plain_char = 7'h30;
            6'h0C: plain_char = 7'h2D;  6'h0D: plain_char = 7'h3D;
            6'h0E: plain_char = 7'h08;  6'h0F: plain_char = 7'h09;
            6'h10: plain_char = 7'h71;  6'h11: plain_char = 7'h77;
            6'h12: plain_char = 7'h65;  6'h13: plain_char = 7'h72;
            6'h14: plain_char = 7'h74;  6'h15: plain_char = 7'h79;
            6'h16: plain_char = 7'h75;  6'h17: plain_char = 7'h69;
            6'h18: plain_char = 7'h6F;  6'h19: plain_char = 7'h70;
            6'h1A: plain_char = 7'h5B;  6'h1B: plain_char = 7'h5D;
            6'h1C: plain_char = 7'h0A;  6'h1E: plain_char = 7'h61;
            6'h1F: plain_char = 7'h73;  6'h20: plain_char = 7'h64;
            6'h21: plain_char = 7'h66;  6'h22: plain_char = 7'h67;
            6'h23: plain_char = 7'h68;  6'h24: plain_char = 7'h6A;
            6'h25: plain_char = 7'h6B;  6'h26: plain_char = 7'h6C;
            6'h27: plain_char = 7'h3B;  6'h28: plain_char = 7'h27;
            6'h29: plain_char = 7'h60;  6'h2B: plain_char = 7'h5C;
            6'h2C: plain_char = 7'h7A;  6'h2D: plain_char = 7'h78;
            6'h2E: plain_char = 7'h63;  6'h2F: plain_char = 7'h76;
            6'h30: plain_char = 7'h62;  6'h31: plain_char = 7'h6E;
            6'h32: plain_char = 7'h6D;  6'h33: plain_char = 7'h2C;
            6'h34: plain_char = 7'h2E;  6'h35: plain_char = 7'h2F;
            6'h37: plain_char = 7'h2A;  6'h39: plain_char = 7'h20;
            default: plain_char = 7'h00;
        endcase
    endfunction

    // shifted character; letters are the upper case of the plain table
    function automatic logic [6:0] shifted_char(input logic [5:0] c);
        logic [6:0] lo;
        lo = plain_char(c);
        case (c)
            6'h02: shifted_char = 7'h21;  6'h03: shifted_char = 7'h40;
            6'h04: shifted_char = 7'h23;  6'h05: shifted_char = 7'h24;
            6'h06: shifted_char = 7'h25;  6'h07: shifted_char = 7'h5E;
            6'h08: shifted_char = 7'h26;  6'h09: shifted_char = 7'h2A;
            6'h0A: shifted_char = 7'h28;  6'h0B: shifted_char = 7'h29;
            6'h0C: shifted_char = 7'h5F;  6'h0D: shifted_char = 7'h2B;
            6'h1A: shifted_char = 7'h7B;  6'h1B: shifted_char = 7'h7D;
            6'h27: shifted_char = 7'h3A;  6'h28: shifted_char = 7'h22;
            6'h29: shifted_char = 7'h7E;  6'h2B: shifted_char = 7'h7C;
            6'h33: shifted_char = 7'h3C;  6'h34: shifted_char = 7'h3E;
            6'h35: shifted_char = 7'h3F;
            default:
            begin
                if (lo >= CH_LOW_A && lo <= CH_LOW_Z)
                    shifted_char = lo ^ CH_CASE;
                else
                    shifted_char = lo;
            end
        endcase
    endfunction

    // keypad digit for ids 0x47..0x52 with num lock on
    function automatic logic [6:0] keypad_digit(input logic [7:0] id);
        case (id)
            8'h47: keypad_digit = 7'h37;  8'h48: keypad_digit = 7'h38;
            8'h49: keypad_digit = 7'h39;  8'h4B: keypad_digit = 7'h34;
            8'h4C: keypad_digit = 7'h35;  8'h4D: keypad_digit = 7'h36;
            8'h4F: keypad_digit = 7'h31;  8'h50: keypad_digit = 7'h32;
            8'h51: keypad_digit = 7'h33;  8'h52: keypad_digit = 7'h30;
            default: keypad_digit = 7'h00;
        endcase
    endfunction

endpackage

@@ rtl/core/ps2_set1_keyboard_to_ascii_unit.sv @@
// top level of the scan code set 1 keyboard decoder
//
// Input channel s_*: one scan code set 1 byte per word in s_tdata.
// Output channel m_*: one key event per word. Bytes that only advance a
// prefix, print screen or pause sequence, and unknown codes, give no word.
// The event carries the key id, press or release, the translated ascii
// character (m_tuser high when there is one) and the three lock toggles.
// A byte accepted goes into the input register; its word is then written
// to the result register, which drives m_*. Throughput: one byte per
// cycle while the receiver takes words; parser state, held modifiers and
// lock toggles all update in the single pass between the two registers.
// Reset clears the parse phase, modifiers and lock toggles and empties
// both registers. When the receiver stalls, the result register holds its
// word; the input register still takes one more byte, and s_tready drops
// only when both are full.
module ps2_set1_keyboard_to_ascii_unit
    import ps2kb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // [7:0] scan_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [RES_W-1:0]    m_tdata,   // [7:0] key_id, [8] pressed,
                                           // [15:9] char_code, [16] caps_lock,
                                           // [17] num_lock, [18] scroll_lock
    output logic                m_tuser    // [0] is_char
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    ps2kb_result_t out_reg;
    logic          advance;
    ps2kb_event_t  ev;
    ps2kb_result_t res;

    // input register moves on when the result register has room
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    ps2kb_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .scan_byte (in_byte_reg),
        .ev        (ev)
    );

    ps2kb_xlate u_xlate
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .ev    (ev),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && ev.valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && ev.valid)
            out_reg <= res;
    end

    // output word packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.is_char;
    assign m_tdata  = {5'd0, out_reg.scroll_lock, out_reg.num_lock, out_reg.caps_lock,
                       out_reg.char_code, out_reg.pressed, out_reg.key_id};

endmodule

@@ rtl/core/ps2kb_parse.sv @@
// scan code sequence parser: prefixes, print screen and pause sequences
module ps2kb_parse
    import ps2kb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   scan_byte,
    output ps2kb_event_t ev
);

    ps2kb_phase_t phase_reg, phase_next;
    logic [7:0]   held_reg, held_next;
    logic [6:0]   code;
    logic         down;

    assign code = scan_byte[6:0];
    assign down = ~scan_byte[7];

    // phase and held byte registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            held_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // next phase and decoded event
    always_comb
    begin
        phase_next = PH_START;
        held_next  = held_reg;
        ev.valid   = 1'b0;
        ev.id      = {1'b0, code};
        ev.down    = down;
        unique case (phase_reg)
            PH_E0:
            begin
                if (scan_byte == BYTE_PS_MAKE || scan_byte == BYTE_PS_BRK)
                begin
                    phase_next = PH_PS_HALF;
                    held_next  = scan_byte;
                end
                else
                begin
                    ev.valid = ext_known(code);
                    ev.id    = {1'b1, code};
                end
            end
            PH_PS_E0:
            begin
                ev.id = KID_PRTSCR;
                if (held_reg == BYTE_PS_BRK && scan_byte == BYTE_PS_REL)
                begin
                    ev.valid = 1'b1;
                    ev.down  = 1'b0;
                end
                else if (held_reg == BYTE_PS_MAKE && scan_byte == BYTE_PS_END)
                begin
                    ev.valid = 1'b1;
                    ev.down  = 1'b1;
                end
            end
            PH_E1:
            begin
                phase_next = PH_E1_MID;
                held_next  = scan_byte;
            end
            PH_E1_MID:
            begin
                ev.id = KID_PAUSE;
                if (held_reg == BYTE_PA_BK1 && scan_byte == BYTE_PA_BK2)
                begin
                    ev.valid = 1'b1;
                    ev.down  = 1'b0;
                end
                else if (held_reg == BYTE_PA_MK1 && scan_byte == BYTE_PA_MK2)
                begin
                    ev.valid = 1'b1;
                    ev.down  = 1'b1;
                end
            end
            default:
            begin
                // start phase; a broken print screen half also lands here
                if (phase_reg == PH_PS_HALF && scan_byte == BYTE_E0)
                    phase_next = PH_PS_E0;
                else if (scan_byte == BYTE_E0)
                    phase_next = PH_E0;
                else if (scan_byte == BYTE_E1)
                    phase_next = PH_E1;
                else
                    ev.valid = plain_known(code);
            end
        endcase
    end

endmodule

@@ rtl/core/ps2kb_xlate.sv @@
// modifier and lock tracking plus ascii translation of key events
module ps2kb_xlate
    import ps2kb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  ps2kb_event_t  ev,
    output ps2kb_result_t res
);

    logic [1:0] shift_reg, shift_next;
    logic [1:0] ctrl_reg, ctrl_next;
    logic [1:0] alt_reg, alt_next;
    logic [2:0] lock_reg, lock_next;
    logic       control, shift, upper, keypad;
    logic [6:0] lo, hi, ch;
    logic [7:0] kid;

    // modifier and lock registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            ctrl_reg  <= '0;
            alt_reg   <= '0;
            lock_reg  <= '0;
        end
        else if (fire && ev.valid)
        begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            alt_reg   <= alt_next;
            lock_reg  <= lock_next;
        end
    end

    // held flags and lock toggles after this event
    always_comb
    begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        alt_next   = alt_reg;
        lock_next  = lock_reg;
        unique case (ev.id)
            KID_LSHIFT: shift_next[0] = ev.down;
            KID_RSHIFT: shift_next[1] = ev.down;
            KID_LCTRL:  ctrl_next[0]  = ev.down;
            KID_RCTRL:  ctrl_next[1]  = ev.down;
            KID_LALT:   alt_next[0]   = ev.down;
            KID_RALT:   alt_next[1]   = ev.down;
            KID_CAPS:   lock_next[0]  = lock_reg[0] ^ ev.down;
            KID_NUM:    lock_next[1]  = lock_reg[1] ^ ev.down;
            KID_SCROLL: lock_next[2]  = lock_reg[2] ^ ev.down;
            default:    ;
        endcase
    end

    // translation, using modifiers from before the event
    assign control = (|ctrl_reg) | (|alt_reg);
    assign shift   = |shift_reg;
    assign upper   = lock_reg[0] ^ shift;
    assign lo      = plain_char(ev.id[5:0]);
    assign hi      = shifted_char(ev.id[5:0]);
    assign keypad  = ev.id >= KID_KP_FIRST && ev.id <= KID_KP_POINT
                     && ev.id != KID_KP_MINUS && ev.id != KID_KP_PLUS;

    always_comb
    begin
        ch  = '0;
        kid = ev.id;
        if (!control)
        begin
            if (ev.id < KID_CHAR_END)
            begin
                if (lo >= CH_LOW_A && lo <= CH_LOW_Z)
                    ch = upper ? hi : lo;
                else
                    ch = shift ? hi : lo;
            end
            else if (ev.id == KID_KP_MINUS)
                ch = CH_MINUS;
            else if (ev.id == KID_KP_PLUS)
                ch = CH_PLUS;
            else if (ev.id == KID_KP_ENTER)
                ch = CH_LF;
            else if (ev.id == KID_KP_DIV)
                ch = CH_SLASH;
        end
        // keypad digits follow num lock as it stands after this event
        if (keypad)
        begin
            ch = '0;
            if (lock_next[1])
            begin
                if (!control)
                    ch = (ev.id == KID_KP_POINT) ? CH_POINT : keypad_digit(ev.id);
            end
            else if (ev.id != KID_KP_FIVE)
                kid = ev.id | 8'h80;
        end
    end

    // result word
    always_comb
    begin
        res.key_id      = kid;
        res.pressed     = ev.down;
        res.is_char     = |ch;
        res.char_code   = ch;
        res.caps_lock   = lock_next[0];
        res.num_lock    = lock_next[1];
        res.scroll_lock = lock_next[2];
    end

endmodule

@@ bench/ps2_set1_keyboard_to_ascii_unit_tb.sv @@
// self-checking testbench for the set 1 scan code to ascii decoder
`timescale 1ns / 1ps

module ps2_set1_keyboard_to_ascii_unit_tb
    import ps2kb_pkg::*;
();

    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [7:0] EXT_BIT     = 8'h80;
    localparam logic [6:0] CH_BS       = 7'h08;
    localparam logic [6:0] CH_TAB      = 7'h09;
    localparam int         QUIET_LIMIT = 5000;
    localparam int         PHASE_BYTES = 300;

    // make codes that have a key behind them after an e0 prefix
    localparam logic [6:0] EXT_CODES [38] = '{
        7'h10, 7'h19, 7'h1C, 7'h1D, 7'h20, 7'h21, 7'h22, 7'h24, 7'h2E, 7'h30,
        7'h32, 7'h35, 7'h38, 7'h47, 7'h48, 7'h49, 7'h4B, 7'h4D, 7'h4F, 7'h50,
        7'h51, 7'h52, 7'h53, 7'h5B, 7'h5C, 7'h5D, 7'h5E, 7'h5F, 7'h63, 7'h65,
        7'h66, 7'h67, 7'h68, 7'h69, 7'h6A, 7'h6B, 7'h6C, 7'h6D
    };

    // tracks the keyboard state and the key event words still awaited
    class key_event_board;
        ps2kb_phase_t    phase = PH_START;
        logic [7:0]      held = '0;
        logic [1:0]      shift_q = '0;
        logic [1:0]      ctrl_q = '0;
        logic [1:0]      alt_q = '0;
        logic [2:0]      locks = '0;
        ps2kb_result_t   awaited_events[$];
        int              errors = 0;
        // '?' marks table slots that are handled by name
        string plain_keys   = "??1234567890-=??qwertyuiop[]??asdfghjkl;'`?\\zxcvbnm,./?*? ";
        string shifted_keys = "??!@#$%^&*()_+??QWERTYUIOP{}??ASDFGHJKL:\"~?|ZXCVBNM<>??*? ";
        string pad_digits   = "789x456x1230";

        function bit plain_id_known(logic [6:0] c);
            return (c >= 7'h01 && c <= 7'h53) || c == 7'h57 || c == 7'h58;
        endfunction

        function bit ext_id_known(logic [6:0] c);
            foreach (EXT_CODES[i])
                if (EXT_CODES[i] == c)
                    return 1'b1;
            return 1'b0;
        endfunction

        function logic [6:0] char_at(string tbl, logic [5:0] c);
            case (c)
                6'h0E: return CH_BS;
                6'h0F: return CH_TAB;
                6'h1C: return CH_LF;
                6'h00, 6'h01, 6'h1D, 6'h2A, 6'h36, 6'h38: return 7'h00;
                default: return 7'(tbl[c]);
            endcase
        endfunction

        // apply one key event to the held state and queue its word
        function void post_key(logic [7:0] id, logic down);
            logic          control;
            logic          shifted;
            logic          upper;
            logic [6:0]    ch;
            logic [6:0]    lo;
            logic [7:0]    kid;
            ps2kb_result_t ev;
            control = (ctrl_q | alt_q) != 2'b00;
            shifted = shift_q != 2'b00;
            upper   = locks[0] ^ shifted;
            ch      = '0;
            kid     = id;

            // modifiers and lock toggles
            case (id)
                KID_LSHIFT: shift_q[0] = down;
                KID_RSHIFT: shift_q[1] = down;
                KID_LCTRL:  ctrl_q[0]  = down;
                KID_RCTRL:  ctrl_q[1]  = down;
                KID_LALT:   alt_q[0]   = down;
                KID_RALT:   alt_q[1]   = down;
                KID_CAPS:   if (down) locks[0] = ~locks[0];
                KID_NUM:    if (down) locks[1] = ~locks[1];
                KID_SCROLL: if (down) locks[2] = ~locks[2];
                default: ;
            endcase

            // character translation, flags taken from before this event
            if (!control)
            begin
                if (id < KID_CHAR_END)
                begin
                    lo = char_at(plain_keys, id[5:0]);
                    if (lo >= CH_LOW_A && lo <= CH_LOW_Z)
                        ch = upper ? char_at(shifted_keys, id[5:0]) : lo;
                    else
                        ch = shifted ? char_at(shifted_keys, id[5:0]) : lo;
                end
                else if (id == KID_KP_MINUS)
                    ch = CH_MINUS;
                else if (id == KID_KP_PLUS)
                    ch = CH_PLUS;
                else if (id == KID_KP_ENTER)
                    ch = CH_LF;
                else if (id == KID_KP_DIV)
                    ch = CH_SLASH;
            end

            // numeric keypad follows num lock
            if (id >= KID_KP_FIRST && id <= KID_KP_POINT
                && id != KID_KP_MINUS && id != KID_KP_PLUS)
            begin
                ch = '0;
                if (locks[1])
                begin
                    if (!control)
                        ch = (id == KID_KP_POINT) ? CH_POINT
                                                  : 7'(pad_digits[id - KID_KP_FIRST]);
                end
                else if (id != KID_KP_FIVE)
                    kid = id | EXT_BIT;
            end

            ev.key_id      = kid;
            ev.pressed     = down;
            ev.is_char     = ch != 7'h00;
            ev.char_code   = ch;
            ev.caps_lock   = locks[0];
            ev.num_lock    = locks[1];
            ev.scroll_lock = locks[2];
            awaited_events.push_back(ev);
        endfunction

        // one accepted scan byte through the sequence parser
        function void take_byte(logic [7:0] b);
            logic [6:0]   code;
            logic         down;
            ps2kb_phase_t ph;
            code = b[6:0];
            down = ~b[7];
            ph   = phase;

            // a broken print screen prefix falls back to a fresh byte
            if (ph == PH_PS_HALF)
            begin
                if (b == BYTE_E0)
                begin
                    phase = PH_PS_E0;
                    return;
                end
                ph = PH_START;
            end

            case (ph)
                PH_E0:
                begin
                    if (b == BYTE_PS_MAKE || b == BYTE_PS_BRK)
                    begin
                        phase = PH_PS_HALF;
                        held  = b;
                        return;
                    end
                    phase = PH_START;
                    if (ext_id_known(code))
                        post_key({1'b1, code}, down);
                end
                PH_PS_E0:
                begin
                    phase = PH_START;
                    if (held == BYTE_PS_BRK && b == BYTE_PS_REL)
                        post_key(KID_PRTSCR, 1'b0);
                    else if (held == BYTE_PS_MAKE && b == BYTE_PS_END)
                        post_key(KID_PRTSCR, 1'b1);
                end
                PH_E1:
                begin
                    phase = PH_E1_MID;
                    held  = b;
                end
                PH_E1_MID:
                begin
                    phase = PH_START;
                    if (held == BYTE_PA_BK1 && b == BYTE_PA_BK2)
                        post_key(KID_PAUSE, 1'b0);
                    else if (held == BYTE_PA_MK1 && b == BYTE_PA_MK2)
                        post_key(KID_PAUSE, 1'b1);
                end
                default:
                begin
                    phase = PH_START;
                    if (b == BYTE_E0)
                        phase = PH_E0;
                    else if (b == BYTE_E1)
                        phase = PH_E1;
                    else if (plain_id_known(code))
                        post_key({1'b0, code}, down);
                end
            endcase
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // compare one received word against the oldest awaited event
        function void match_word(logic [RES_W-1:0] data, logic user);
            ps2kb_result_t want;
            if (awaited_events.size() == 0)
            begin
                $display("%0t: unexpected word, expected none actual %h/%b", $time, data, user);
                errors++;
                return;
            end
            want = awaited_events.pop_front();
            check_field("key_id", want.key_id, data[7:0]);
            check_field("pressed", want.pressed, data[8]);
            check_field("is_char", want.is_char, user);
            check_field("char_code", want.char_code, data[15:9]);
            check_field("caps_lock", want.caps_lock, data[16]);
            check_field("num_lock", want.num_lock, data[17]);
            check_field("scroll_lock", want.scroll_lock, data[18]);
        endfunction

        function int outstanding();
            return awaited_events.size();
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [RES_W-1:0]  m_tdata;
    logic              m_tuser;

    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                bytes_sent = 0;
    int                quiet_cycles = 0;
    key_event_board    key_events;
    logic [7:0]        opening_bytes[$];

    ps2_set1_keyboard_to_ascii_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: check accepted words, stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            key_events.match_word(m_tdata, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // present one scan byte, with random gaps ahead of it
    task automatic push_scan_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        key_events.take_byte(b);
        bytes_sent++;
    endtask

    // hold the sender until every awaited word has come out
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (key_events.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] break_if(logic rel);
        return rel ? BREAK_BIT : 8'h00;
    endfunction

    // one random well-formed key sequence, or some noise
    task automatic push_random_sequence();
        int         pick;
        int         r;
        logic       rel;
        logic [6:0] code;
        pick = $urandom_range(0, 99);
        rel  = 1'($urandom_range(0, 1));
        if (pick < 45)
        begin
            r = $urandom_range(1, 8'h55);
            code = 7'((r > 8'h53) ? r + 3 : r);
            push_scan_byte({1'b0, code} | break_if(rel));
        end
        else if (pick < 60)
        begin
            code = EXT_CODES[$urandom_range(0, 37)];
            push_scan_byte(BYTE_E0);
            push_scan_byte({1'b0, code} | break_if(rel));
        end
        else if (pick < 72)
        begin
            // modifiers and locks, released more often than pressed
            rel = $urandom_range(0, 99) < 60;
            case ($urandom_range(0, 7))
                0: push_scan_byte(KID_LSHIFT | break_if(rel));
                1: push_scan_byte(KID_RSHIFT | break_if(rel));
                2: push_scan_byte(KID_LCTRL | break_if(rel));
                3: push_scan_byte(KID_LALT | break_if(rel));
                4: push_scan_byte(KID_CAPS | break_if(rel));
                5: push_scan_byte(KID_NUM | break_if(rel));
                6: push_scan_byte(KID_SCROLL | break_if(rel));
                default:
                begin
                    push_scan_byte(BYTE_E0);
                    push_scan_byte(($urandom_range(0, 1) ? KID_LCTRL : KID_LALT)
                                   | break_if(rel));
                end
            endcase
        end
        else if (pick < 77)
        begin
            push_scan_byte(BYTE_E0);
            push_scan_byte(rel ? BYTE_PS_BRK : BYTE_PS_MAKE);
            push_scan_byte(BYTE_E0);
            push_scan_byte(rel ? BYTE_PS_REL : BYTE_PS_END);
        end
        else if (pick < 82)
        begin
            push_scan_byte(BYTE_E1);
            push_scan_byte(rel ? BYTE_PA_BK1 : BYTE_PA_MK1);
            push_scan_byte(rel ? BYTE_PA_BK2 : BYTE_PA_MK2);
        end
        else if (pick < 92)
            push_scan_byte(8'($urandom_range(0, 255)));
        else
        begin
            // broken print screen and pause sequences
            case ($urandom_range(0, 2))
                0:
                begin
                    push_scan_byte(BYTE_E0);
                    push_scan_byte(rel ? BYTE_PS_BRK : BYTE_PS_MAKE);
                    push_scan_byte(8'($urandom_range(0, 255)));
                end
                1:
                begin
                    push_scan_byte(BYTE_E0);
                    push_scan_byte(rel ? BYTE_PS_BRK : BYTE_PS_MAKE);
                    push_scan_byte(BYTE_E0);
                    push_scan_byte(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    push_scan_byte(BYTE_E1);
                    push_scan_byte($urandom_range(0, 1) ? BYTE_PA_MK1
                                                        : 8'($urandom_range(0, 255)));
                    push_scan_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    initial
    begin
        key_events = new();
        opening_bytes = '{
            8'h00, 8'hFF, 8'h1E, KID_CAPS, 8'h1E, KID_LSHIFT, 8'h1E, 8'h02,
            KID_LSHIFT | BREAK_BIT, KID_CAPS | BREAK_BIT, KID_NUM, KID_KP_FIRST,
            KID_KP_POINT, KID_KP_FIVE, BYTE_E0, KID_LCTRL, KID_KP_FIRST, BYTE_E0, KID_RCTRL,
            KID_NUM, KID_KP_FIRST, KID_KP_POINT, KID_KP_FIVE,
            BYTE_E0, BYTE_PS_MAKE, BYTE_E0, BYTE_PS_END, BYTE_E0, BYTE_PS_BRK, BYTE_E0,
            BYTE_PS_REL, BYTE_E1, BYTE_PA_MK1, BYTE_PA_MK2, BYTE_E1, BYTE_PA_BK1, BYTE_PA_BK2,
            BYTE_E0, BYTE_PS_MAKE, 8'h1E, BYTE_E0, BYTE_PS_BRK, BYTE_E0, 8'h1E,
            BYTE_E1, 8'h11, 8'h22, BYTE_E0, 8'h01, KID_SCROLL, BYTE_E0, 8'h35, 8'h0E
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed bytes, then random sequences, sender idling lightly first
        send_idle_pct = 17;
        recv_idle_pct = 87;
        foreach (opening_bytes[i])
            push_scan_byte(opening_bytes[i]);
        wait_all_results();

        bytes_sent = 0;
        while (bytes_sent < PHASE_BYTES)
            push_random_sequence();
        wait_all_results();

        send_idle_pct = 87;
        recv_idle_pct = 17;
        bytes_sent = 0;
        while (bytes_sent < PHASE_BYTES)
            push_random_sequence();
        wait_all_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        bytes_sent = 0;
        while (bytes_sent < PHASE_BYTES)
            push_random_sequence();

        // drain and let the pipeline settle
        wait_all_results();
        repeat (10) @(posedge clk);
        if (key_events.errors == 0 && key_events.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ ps2_set1_keyboard_to_ascii_unit.f @@
rtl/core/ps2kb_pkg.sv
rtl/core/ps2kb_parse.sv
rtl/core/ps2kb_xlate.sv
rtl/core/ps2_set1_keyboard_to_ascii_unit.sv
bench/ps2_set1_keyboard_to_ascii_unit_tb.sv
